// ===== hw/rtl/lzwd_pkg.sv =====
// ----------------------------------------------------------------------------
// lzwd_pkg
// Shared constants, types and the code word decoder for the LZ word decompressor.
// ----------------------------------------------------------------------------
package lzwd_pkg;

  localparam int WORD_W            = 16;
  localparam int DIST_W            = 15;
  localparam int LEN_W             = 3;
  localparam int WINDOW_DEPTH_DEF  = 16384;

  localparam logic [WORD_W-1:0] ESCAPE_WORD = 16'hFFFF;
  localparam logic [WORD_W-1:0] BAND_5      = 16'h4000;
  localparam logic [WORD_W-1:0] BAND_4      = 16'h2000;
  localparam logic [WORD_W-1:0] BAND_3      = 16'h1000;

  localparam logic [LEN_W-1:0]  LEN_2 = 3'd2;
  localparam logic [LEN_W-1:0]  LEN_3 = 3'd3;
  localparam logic [LEN_W-1:0]  LEN_4 = 3'd4;
  localparam logic [LEN_W-1:0]  LEN_5 = 3'd5;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [DIST_W-1:0] offset;
  } backref_t;

  function automatic backref_t decode_ref(input logic [WORD_W-1:0] cw);
    logic [WORD_W-1:0] v;
    backref_t          r;
    v = ~cw + 16'd1;
    if (v > BAND_5) begin
      r.len    = LEN_5;
      r.offset = DIST_W'(v - BAND_5);
    end else if (v > BAND_4) begin
      r.len    = LEN_4;
      r.offset = DIST_W'(v - BAND_4);
    end else if (v > BAND_3) begin
      r.len    = LEN_3;
      r.offset = DIST_W'(v - BAND_3);
    end else begin
      r.len    = LEN_2;
      r.offset = DIST_W'(v);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/lzwd_ram.sv =====
// ----------------------------------------------------------------------------
// lzwd_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module lzwd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/lzwd_ctrl.sv =====
// ----------------------------------------------------------------------------
// lzwd_ctrl
// Code word sequencer: decodes requests, drives the history RAM with
// write-to-read forwarding, and holds the output register.
// ----------------------------------------------------------------------------
module lzwd_ctrl #(
  parameter int WINDOW_DEPTH = lzwd_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [lzwd_pkg::WORD_W-1:0]       s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [lzwd_pkg::WORD_W-1:0]       m_tdata,
  output logic                              m_tlast,
  output logic                              mem_we,
  output logic [$clog2(WINDOW_DEPTH)-1:0]   mem_waddr,
  output logic [lzwd_pkg::WORD_W-1:0]       mem_wdata,
  output logic [$clog2(WINDOW_DEPTH)-1:0]   mem_raddr,
  input  logic [lzwd_pkg::WORD_W-1:0]       mem_rdata
);

  localparam int AW = $clog2(WINDOW_DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_COPY = 1'b1;

  logic                           state;
  logic                           esc;
  logic [AW-1:0]                  wp;
  logic [lzwd_pkg::LEN_W-1:0]     cnt;
  logic [lzwd_pkg::DIST_W-1:0]    offset;
  logic                           fwd_hit;
  logic [lzwd_pkg::WORD_W-1:0]    fwd_data;

  logic                           can_emit;
  logic                           acc;
  logic                           is_esc;
  logic                           is_ref;
  lzwd_pkg::backref_t             dec;
  logic                           emit_copy;
  logic [lzwd_pkg::WORD_W-1:0]    copy_word;
  logic [AW-1:0]                  wp_inc;
  logic [AW-1:0]                  rd_base;
  logic [lzwd_pkg::DIST_W-1:0]    dsel;
  logic [AW:0]                    diff;
  logic [AW:0]                    diff_wrap;

  assign can_emit  = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE) && can_emit;
  assign acc       = s_tvalid && s_tready;
  assign dec       = lzwd_pkg::decode_ref(s_tdata);
  assign is_esc    = !esc && (s_tdata == lzwd_pkg::ESCAPE_WORD);
  assign is_ref    = !esc && s_tdata[lzwd_pkg::WORD_W-1] && !is_esc;
  assign emit_copy = (state == ST_COPY) && can_emit;
  assign copy_word = fwd_hit ? fwd_data : mem_rdata;
  assign wp_inc    = (wp == AW'(WINDOW_DEPTH - 1)) ? '0 : wp + 1'b1;

  assign rd_base   = emit_copy ? wp_inc : wp;
  assign dsel      = (state == ST_COPY) ? offset : dec.offset;
  assign diff      = {1'b0, rd_base} - (AW+1)'(dsel);
  assign diff_wrap = diff + (AW+1)'(WINDOW_DEPTH);
  assign mem_raddr = diff[AW] ? diff_wrap[AW-1:0] : diff[AW-1:0];

  assign mem_we    = (acc && !is_esc && !is_ref) || emit_copy;
  assign mem_waddr = wp;
  assign mem_wdata = emit_copy ? copy_word : s_tdata;

  always_ff @(posedge clk) begin
    fwd_data <= mem_wdata;
    if (rst) begin
      state    <= ST_IDLE;
      esc      <= 1'b0;
      wp       <= '0;
      m_tvalid <= 1'b0;
      fwd_hit  <= 1'b0;
      cnt      <= '0;
      offset   <= '0;
    end else begin
      fwd_hit <= mem_we && (mem_raddr == mem_waddr);
      if (mem_we) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (acc) begin
            if (is_esc) begin
              esc <= 1'b1;
            end else if (is_ref) begin
              state  <= ST_COPY;
              cnt    <= dec.len;
              offset <= dec.offset;
            end else begin
              esc      <= 1'b0;
              m_tdata  <= s_tdata;
              m_tlast  <= 1'b1;
              wp       <= wp_inc;
            end
          end
        end
        ST_COPY: begin
          if (can_emit) begin
            m_tdata  <= copy_word;
            m_tlast  <= (cnt == lzwd_pkg::LEN_W'(1));
            wp       <= wp_inc;
            cnt      <= cnt - 1'b1;
            if (cnt == lzwd_pkg::LEN_W'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/lz_word_decompressor.sv =====
// ----------------------------------------------------------------------------
// lz_word_decompressor
// Decodes 16-bit LZ code words (literal, escape, back-reference) into
// 16-bit output words, keeping the output history in a RAM window.
// ----------------------------------------------------------------------------
// Channel   Dir  Fields (tdata low bit up)          Per request
// s_*       in   tdata[15:0] code_word               one code word
// m_*       out  tdata[15:0] out_word, tlast          one output word, tlast
//                            last_of_run               on the last of a run
//
// Literals, escaped words and escapes are accepted only while no copy is running; a
// back-reference of length L (2..5) does one history RAM read per word, the
// first issued as the code word is accepted. Reset clears the sequencer,
// write pointer and m_tvalid only; the history RAM is not cleared. A stalled
// m_tready holds the copy and reissues the pending history read.
// ----------------------------------------------------------------------------
module lz_word_decompressor #(
  parameter int WINDOW_DEPTH = lzwd_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [lzwd_pkg::WORD_W-1:0] s_tdata,   // [15:0] code_word
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [lzwd_pkg::WORD_W-1:0] m_tdata,   // [15:0] out_word
  output logic                        m_tlast
);

  localparam int AW = $clog2(WINDOW_DEPTH);

  logic                        mem_we;
  logic [AW-1:0]               mem_waddr;
  logic [lzwd_pkg::WORD_W-1:0] mem_wdata;
  logic [AW-1:0]               mem_raddr;
  logic [lzwd_pkg::WORD_W-1:0] mem_rdata;

  lzwd_ctrl #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  lzwd_ram #(
    .WIDTH(lzwd_pkg::WORD_W),
    .DEPTH(WINDOW_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
